### rtl/frrd_pkg.sv
// ----------------------------------------------------------------------------
// frrd_pkg
// Constants shared by the frame receiver: response codes, frame lengths,
// result kinds, parser phases and configuration register indexes.
// ----------------------------------------------------------------------------
package frrd_pkg;

    // Configuration register indexes and reset values.
    localparam logic [1:0] REG_HEADER_BYTE = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd1;
    localparam logic [7:0] HEADER_RESET    = 8'hCC;
    localparam logic [6:0] MAX_LEN_RESET   = 7'd100;

    // Parser phases.
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Response command bytes (payload byte 0) and their frame lengths.
    localparam logic [7:0] CMD_VERSION = 8'hAC;
    localparam logic [7:0] CMD_NETWORK = 8'hAD;
    localparam logic [7:0] CMD_CLOCK   = 8'hE0;
    localparam logic [7:0] CMD_SENSOR  = 8'h77;
    localparam logic [7:0] SENSOR_SUB  = 8'hF0;
    localparam logic [7:0] LEN_VERSION = 8'h33;
    localparam logic [7:0] LEN_NETWORK = 8'h0E;
    localparam logic [7:0] LEN_CLOCK   = 8'h10;

    // Byte streams: first payload index and length of the version stream.
    localparam logic [7:0] VERSION_FIRST = 8'd3;
    localparam logic [7:0] SENSOR_FIRST  = 8'd4;
    localparam logic [7:0] SUB_INDEX     = 8'd3;
    localparam logic [5:0] VERSION_BYTES = 6'd48;

    // Result kinds.
    localparam logic [1:0] KIND_VERSION = 2'd0;
    localparam logic [1:0] KIND_NETWORK = 2'd1;
    localparam logic [1:0] KIND_CLOCK   = 2'd2;
    localparam logic [1:0] KIND_SENSOR  = 2'd3;

    // Record gather lengths.
    localparam logic [5:0] NET_FIELDS   = 6'd5;
    localparam logic [5:0] CLOCK_FIELDS = 6'd6;

    // Payload index of gathered record byte number idx.
    function automatic logic [7:0] gather_addr(input logic is_clock, input logic [2:0] idx);
        logic [7:0] a;
        a = 8'd0;
        if (is_clock) begin
            unique case (idx)
                3'd0:    a = 8'd9;
                3'd1:    a = 8'd10;
                3'd2:    a = 8'd11;
                3'd3:    a = 8'd13;
                3'd4:    a = 8'd14;
                3'd5:    a = 8'd15;
                default: a = 8'd0;
            endcase
        end else begin
            unique case (idx)
                3'd0:    a = 8'd1;
                3'd1:    a = 8'd2;
                3'd2:    a = 8'd11;
                3'd3:    a = 8'd12;
                3'd4:    a = 8'd13;
                default: a = 8'd0;
            endcase
        end
        return a;
    endfunction

endpackage

### rtl/frame_receiver_response_decoder_core.sv
// ----------------------------------------------------------------------------
// frame_receiver_response_decoder_core
// Byte-wise frame parser with a payload memory and a response decoder.
// ----------------------------------------------------------------------------
// The block takes one received byte per request and accepts a new byte in the
// cycle after the previous one while a frame is being collected. Payload bytes
// go into a synchronous memory of PAYLOAD_BYTES entries with one write port
// and one registered read port. When the byte count reaches the frame length,
// input stalls while the decoder reads the memory: ST_CMD, ST_SUB and ST_DEC
// fetch the command and subcommand bytes, then ST_SRD and ST_SOUT give each
// result of the version and sensor streams (48 and RECORD_BYTES results), or
// ST_GATHER reads each byte and ST_GOUT gives a network or clock record, with
// waits on m_ready held in ST_SOUT and ST_GOUT. Other frames end after ST_DEC.
module frame_receiver_response_decoder_core #(
    parameter int PAYLOAD_BYTES = 128,
    parameter int RECORD_BYTES  = 6
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_short_addr,
    output logic [7:0]  m_radio_channel,
    output logic [15:0] m_pan_id,
    output logic [7:0]  m_year,
    output logic [7:0]  m_month,
    output logic [7:0]  m_day,
    output logic [7:0]  m_hour,
    output logic [7:0]  m_minute,
    output logic [7:0]  m_second,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);
    import frrd_pkg::*;

    localparam int AW = $clog2(PAYLOAD_BYTES);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CMD    = 4'd1;
    localparam logic [3:0] ST_SUB    = 4'd2;
    localparam logic [3:0] ST_DEC    = 4'd3;
    localparam logic [3:0] ST_SRD    = 4'd4;
    localparam logic [3:0] ST_SOUT   = 4'd5;
    localparam logic [3:0] ST_GATHER = 4'd6;
    localparam logic [3:0] ST_GOUT   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [7:0] header_reg;
    logic [6:0] max_len_reg;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       sensor_reg, sensor_next;   // stream kind: sensor, else version
    logic       clock_reg, clock_next;     // record kind: clock, else network
    logic [5:0] idx_reg, idx_next;
    logic [7:0] gbuf_reg [6];

    logic [7:0]    mem [PAYLOAD_BYTES];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    logic        in_acc;
    logic        out_free;
    logic        decode_go;
    logic [7:0]  count_inc;
    logic [5:0]  stream_len;
    logic [7:0]  stream_first;
    logic [5:0]  gather_len;
    logic [8:0]  stream_addr;

    logic        out_load;
    logic        m_valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] saddr_reg, saddr_next;
    logic [7:0]  chan_reg, chan_next;
    logic [15:0] pan_reg, pan_next;
    logic [7:0]  year_reg, year_next;
    logic [7:0]  month_reg, month_next;
    logic [7:0]  day_reg, day_next;
    logic [7:0]  hour_reg, hour_next;
    logic [7:0]  minute_reg, minute_next;
    logic [7:0]  second_reg, second_next;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign count_inc = count_reg + 8'd1;

    assign stream_len   = sensor_reg ? 6'(RECORD_BYTES) : VERSION_BYTES;
    assign stream_first = sensor_reg ? SENSOR_FIRST : VERSION_FIRST;
    assign gather_len   = clock_reg ? CLOCK_FIELDS : NET_FIELDS;
    assign stream_addr  = {1'b0, stream_first} + {3'b000, idx_reg};

    // Byte parser.
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        decode_go  = 1'b0;
        if (in_acc) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == header_reg) begin
                        count_next = 8'd0;
                        len_next   = 8'hFF;
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (s_rx_byte > {1'b0, max_len_reg}) begin
                        phase_next = PH_HUNT;
                        len_next   = 8'd0;
                        count_next = 8'd0;
                    end else begin
                        len_next   = s_rx_byte;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if ({1'b0, count_reg} < 9'(PAYLOAD_BYTES) && count_reg <= len_reg) begin
                        wr_en      = 1'b1;
                        count_next = count_inc;
                        if (count_inc == len_reg) begin
                            // The frame length stays for the decoder; the next
                            // header reloads it.
                            decode_go  = 1'b1;
                            phase_next = PH_HUNT;
                            count_next = 8'd0;
                        end
                    end else begin
                        phase_next = PH_HUNT;
                        len_next   = 8'd0;
                        count_next = 8'd0;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                end
            endcase
        end
    end

    // Read address of the decode sequencer.
    always_comb begin
        unique case (state_reg)
            ST_CMD:    rd_addr = '0;
            ST_SUB:    rd_addr = AW'(SUB_INDEX);
            ST_GATHER: rd_addr = AW'(gather_addr(clock_reg, idx_reg[2:0]));
            default:   rd_addr = stream_addr[AW-1:0];
        endcase
    end

    // Decode sequencer and result register loading.
    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        sensor_next = sensor_reg;
        clock_next  = clock_reg;
        idx_next    = idx_reg;
        out_load    = 1'b0;
        kind_next   = kind_reg;
        saddr_next  = 16'd0;
        chan_next   = 8'd0;
        pan_next    = 16'd0;
        year_next   = 8'd0;
        month_next  = 8'd0;
        day_next    = 8'd0;
        hour_next   = 8'd0;
        minute_next = 8'd0;
        second_next = 8'd0;
        data_next   = 8'd0;
        last_next   = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (decode_go) begin
                    state_next = ST_CMD;
                end
            end
            ST_CMD: begin
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd_next   = rd_data_reg;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                idx_next   = 6'd0;
                state_next = ST_IDLE;
                if (cmd_reg == CMD_VERSION && len_reg == LEN_VERSION) begin
                    sensor_next = 1'b0;
                    state_next  = ST_SRD;
                end else if (cmd_reg == CMD_NETWORK && len_reg == LEN_NETWORK) begin
                    clock_next = 1'b0;
                    state_next = ST_GATHER;
                end else if (cmd_reg == CMD_CLOCK && len_reg == LEN_CLOCK) begin
                    clock_next = 1'b1;
                    state_next = ST_GATHER;
                end else if (cmd_reg == CMD_SENSOR && rd_data_reg == SENSOR_SUB
                             && len_reg == 8'(RECORD_BYTES + 4)) begin
                    sensor_next = 1'b1;
                    state_next  = ST_SRD;
                end
            end
            ST_SRD: begin
                state_next = ST_SOUT;
            end
            ST_SOUT: begin
                // The read address holds while the result register is busy.
                if (out_free) begin
                    out_load   = 1'b1;
                    kind_next  = sensor_reg ? KIND_SENSOR : KIND_VERSION;
                    data_next  = rd_data_reg;
                    last_next  = (idx_reg == stream_len - 6'd1);
                    idx_next   = idx_reg + 6'd1;
                    state_next = (idx_reg == stream_len - 6'd1) ? ST_IDLE : ST_SRD;
                end
            end
            ST_GATHER: begin
                if (idx_reg == gather_len) begin
                    state_next = ST_GOUT;
                end else begin
                    idx_next = idx_reg + 6'd1;
                end
            end
            ST_GOUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (clock_reg) begin
                        kind_next   = KIND_CLOCK;
                        year_next   = gbuf_reg[0];
                        month_next  = gbuf_reg[1];
                        day_next    = gbuf_reg[2];
                        hour_next   = gbuf_reg[3];
                        minute_next = gbuf_reg[4];
                        second_next = gbuf_reg[5];
                    end else begin
                        kind_next  = KIND_NETWORK;
                        saddr_next = {gbuf_reg[1], gbuf_reg[0]};
                        chan_next  = gbuf_reg[2];
                        pan_next   = {gbuf_reg[4], gbuf_reg[3]};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Payload memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= s_rx_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GATHER && idx_reg != 6'd0) begin
            gbuf_reg[3'(idx_reg - 6'd1)] <= rd_data_reg;
        end
        cmd_reg    <= cmd_next;
        sensor_reg <= sensor_next;
        clock_reg  <= clock_next;
        idx_reg    <= idx_next;
        if (out_load) begin
            kind_reg   <= kind_next;
            saddr_reg  <= saddr_next;
            chan_reg   <= chan_next;
            pan_reg    <= pan_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            data_reg   <= data_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_HUNT;
            len_reg     <= 8'd0;
            count_reg   <= 8'd0;
            header_reg  <= HEADER_RESET;
            max_len_reg <= MAX_LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HEADER_BYTE) begin
                    header_reg <= cfg_data;
                end else if (cfg_index == REG_MAX_LENGTH) begin
                    max_len_reg <= cfg_data[6:0];
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_short_addr    = saddr_reg;
    assign m_radio_channel = chan_reg;
    assign m_pan_id        = pan_reg;
    assign m_year          = year_reg;
    assign m_month         = month_reg;
    assign m_day           = day_reg;
    assign m_hour          = hour_reg;
    assign m_minute        = minute_reg;
    assign m_second        = second_reg;
    assign m_data_byte     = data_reg;
    assign m_last          = last_reg;

endmodule
